>>> src/swrr_pkg.sv
// Shared types and constants for the smooth weighted round-robin picker.
`timescale 1ns / 1ps

package swrr_pkg;

  localparam int unsigned MaxSlots = 8;
  localparam int unsigned WeightW  = 8;
  localparam int unsigned CreditW  = 16;
  localparam int unsigned TotalW   = 11;
  localparam int unsigned CountW   = 4;

  localparam logic [63:0] WeightReset = 64'h0101_0101_0101_0101;

  localparam logic REG_BACKEND_CNT  = 1'b0;
  localparam logic REG_WEIGHT_TABLE = 1'b1;

  localparam logic signed [CreditW-1:0] CreditMax = 16'sh7fff;
  localparam logic signed [CreditW-1:0] CreditMin = -16'sh8000;

  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

>>> src/swrr_ctrl.sv
// Controller state machine that sequences the scan, write-back and result transfer.
`timescale 1ns / 1ps

module swrr_ctrl
  import swrr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        if (status_i.scan_done) begin
          state_d = StFinish;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StFinish: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

>>> src/swrr_dp.sv
// Datapath with configuration, credit registers, scan accumulator and output register.
`timescale 1ns / 1ps

module swrr_dp
  import swrr_pkg::*;
#(
  parameter int unsigned Slots = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i,
  input  logic [7:0]   up_mask_i,
  input  logic [7:0]   trial_mask_i,
  input  logic         out_stall_i,
  output logic         out_valid_o,
  output logic [2:0]   node_index_o,
  output logic         found_o,
  input  cmd_t         cmd_i,
  output status_t      status_o
);

  localparam int unsigned IdxW = $clog2(Slots);
  localparam logic [CountW-1:0] SlotsCnt = CountW'(Slots);

  logic [CountW-1:0]         backend_cnt_q;
  logic [63:0]               weight_table_q;
  logic signed [CreditW-1:0] credit_q [Slots];
  logic [7:0]                up_q, trial_q;
  logic [CountW-1:0]         cnt_q;
  logic [TotalW-1:0]         total_q;
  logic                      have_q;
  logic [IdxW-1:0]           best_q;
  logic signed [CreditW-1:0] best_cr_q;
  logic                      out_valid_q;
  logic [2:0]                node_index_q;
  logic                      found_q;

  logic [CountW-1:0]         active_n;
  logic [WeightW-1:0]        weight;
  logic                      part;
  logic signed [CreditW:0]   sum_wide;
  logic signed [CreditW-1:0] sum_sat;
  logic signed [CreditW:0]   diff_wide;
  logic signed [CreditW-1:0] diff_sat;
  logic                      trial_hit;
  logic [2:0]                trial_idx;
  logic [IdxW-1:0]           slot;

  assign active_n = (backend_cnt_q > SlotsCnt) ? SlotsCnt : backend_cnt_q;
  assign slot     = cnt_q[IdxW-1:0];
  assign weight   = weight_table_q[WeightW*cnt_q[2:0] +: WeightW];
  assign part     = up_q[cnt_q[2:0]] && (weight != '0);

  assign sum_wide = {credit_q[slot][CreditW-1], credit_q[slot]}
                  + $signed({{(CreditW+1-WeightW){1'b0}}, weight});
  assign sum_sat  = (sum_wide > $signed({1'b0, CreditMax})) ? CreditMax
                                                            : sum_wide[CreditW-1:0];

  assign diff_wide = {best_cr_q[CreditW-1], best_cr_q}
                   - $signed({{(CreditW+1-TotalW){1'b0}}, total_q});
  assign diff_sat  = (diff_wide < $signed({1'b1, CreditMin})) ? CreditMin
                                                              : diff_wide[CreditW-1:0];

  always_comb begin
    trial_hit = 1'b0;
    trial_idx = '0;
    for (int i = MaxSlots - 1; i >= 0; i--) begin
      if (trial_q[i] && (CountW'(i) < active_n)) begin
        trial_hit = 1'b1;
        trial_idx = 3'(i);
      end
    end
  end

  assign status_o.scan_done = (cnt_q >= active_n);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backend_cnt_q  <= '0;
      weight_table_q <= WeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BACKEND_CNT:  backend_cnt_q  <= cfg_wdata_i[CountW-1:0];
        REG_WEIGHT_TABLE: weight_table_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        credit_q[i] <= '0;
      end
      cnt_q       <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        cnt_q  <= '0;
        have_q <= 1'b0;
      end
      if (cmd_i.step) begin
        cnt_q <= cnt_q + 1'b1;
        if (part) begin
          credit_q[slot] <= sum_sat;
          if (!have_q || (sum_sat > best_cr_q)) begin
            have_q <= 1'b1;
          end
        end
      end
      if (cmd_i.finish && have_q) begin
        credit_q[best_q] <= diff_sat;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      up_q    <= up_mask_i;
      trial_q <= trial_mask_i;
      total_q <= '0;
    end
    if (cmd_i.step && part) begin
      total_q <= total_q + TotalW'(weight);
      if (!have_q || (sum_sat > best_cr_q)) begin
        best_q    <= slot;
        best_cr_q <= sum_sat;
      end
    end
    if (cmd_i.finish) begin
      if (have_q) begin
        node_index_q <= 3'(best_q);
        found_q      <= 1'b1;
      end else begin
        node_index_q <= trial_idx;
        found_q      <= trial_hit;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign node_index_o = node_index_q;
  assign found_o      = found_q;

endmodule

>>> src/smooth_weighted_round_robin.sv
// Top level of the smooth weighted round-robin picker.
//
//   Channel   Direction  Handshake              Payload
//   cfg       in         cfg_we_i               cfg_idx_i, cfg_wdata_i
//   in        in         in_valid_i/in_stall_o  up_mask_i, trial_mask_i
//   out       out        out_valid_o/out_stall_i node_index_o, found_o
//
// A pick is transferred in, then the credit of each active backend is scanned in turn
// through the single credit adder and comparator (the active backend count is at most
// eight), followed by a scan-end and a finish state, after which the result is valid.
// The next pick can be taken in the cycle after the finish; until then the input stalls.
// After reset all credits are zero, every weight is one and the backend count is zero.
// A stalled result holds back the finish of the next pick until it drains.
`timescale 1ns / 1ps

module smooth_weighted_round_robin
  import swrr_pkg::*;
#(
  parameter int unsigned NODES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  up_mask_i,
  input  logic [7:0]  trial_mask_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  node_index_o,
  output logic        found_o
);

  localparam int unsigned Slots = (NODES < MaxSlots) ? NODES : MaxSlots;

  cmd_t    cmd;
  status_t status;

  swrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swrr_dp #(
    .Slots (Slots)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .up_mask_i    (up_mask_i),
    .trial_mask_i (trial_mask_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .node_index_o (node_index_o),
    .found_o      (found_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

  a_cmd_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start, cmd.step, cmd.finish}))
    else $error("more than one datapath command at once");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled while a pick is in progress");

  a_finish_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o)
    else $error("finished pick did not produce a result");

  a_none_found_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (node_index_o == 3'd0))
    else $error("nonzero index on a pick that found nothing");

endmodule
